@@ rtl/hbw_pkg.sv @@
// Shared constants, codes and transaction types of the heartbeat watchdog.
package hbw_pkg;

  localparam int NUM_SLOTS    = 8;
  localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_FIELD_W = 3;
  localparam int TICK_W       = 32;
  localparam int TIMEOUT_W    = 31;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd300;

  typedef enum logic [1:0] {
    OP_REG   = 2'd0,
    OP_KICK  = 2'd1,
    OP_UNREG = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_REGISTERED = 3'd0,
    EV_FULL       = 3'd1,
    EV_ACK        = 3'd2,
    EV_RESTART    = 3'd3,
    EV_DONE       = 3'd4
  } ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_SCAN = 2'd1,
    B_DONE = 2'd2
  } back_state_t;

  // Classified command handed from the front queue to the engine
  typedef struct packed {
    op_t                     op;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    slot_ok;
    logic [TICK_W-1:0]       now;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    ev_t                     ev;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TICK_W-1:0]       total;
    logic                    last;
  } res_t;

endpackage

@@ rtl/hbw_front.sv @@
// Front end: accepts input transactions, classifies them and queues them.
module hbw_front import hbw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              kind,
  input  logic [SLOT_FIELD_W-1:0] slot,
  input  logic [TICK_W-1:0]       now_tick,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  input  logic                    cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  cmd_t       cmd_in;

  // Classify the incoming transaction
  always_comb begin
    cmd_in.op      = op_t'(kind);
    cmd_in.slot    = slot;
    cmd_in.slot_ok = (int'(slot) < NUM_SLOTS);
    cmd_in.now     = now_tick;
  end

  assign full      = (count == 2'd2);
  assign wr_en     = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // Store classified commands
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, cmd_pop};
    end
  end

endmodule

@@ rtl/hbw_engine.sv @@
// Back end: slot table, timeout scan, restart counter and result queue.
module hbw_engine import hbw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  input  logic                  res_pop,
  output logic                  res_empty,
  output res_t                  res
);

  // Configuration registers
  logic                 enable;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  // Slot table
  logic [NUM_SLOTS-1:0] slot_in_use;
  logic [TICK_W-1:0]    last_heartbeat [NUM_SLOTS];
  logic [TICK_W-1:0]    restart_counter;

  // Sequencer
  back_state_t          state;
  back_state_t          state_next;
  logic [SLOT_W-1:0]    idx;

  // Result queue
  res_t                 rq [2];
  logic                 rq_wr_ptr;
  logic                 rq_rd_ptr;
  logic [1:0]           rq_count;
  logic                 space;
  logic                 res_rd;

  // Strobes from the output block
  logic                 res_wr;
  res_t                 res_in;
  logic                 hb_wr;
  logic [SLOT_W-1:0]    hb_idx;
  logic                 use_set;
  logic                 use_clr;
  logic                 cnt_inc;
  logic                 idx_step;

  // Lookups
  logic                 free_any;
  logic [SLOT_W-1:0]    free_idx;
  logic [SLOT_W-1:0]    cmd_idx;
  logic [TICK_W-1:0]    idle_ticks;
  logic                 hit;
  logic                 scan_end;

  assign space     = (rq_count != 2'd2);
  assign res_rd    = res_pop && !res_empty;
  assign res_empty = (rq_count == 2'd0);
  assign res       = rq[rq_rd_ptr];
  assign cmd_idx   = SLOT_W'(cmd.slot);
  assign scan_end  = (idx == SLOT_W'(NUM_SLOTS - 1));

  // Find the lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_in_use[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Wrap-safe idle time of the slot under scan
  assign idle_ticks = cmd.now - last_heartbeat[idx];
  assign hit        = slot_in_use[idx] && (idle_ticks > {1'b0, timeout_ticks});

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_valid && cmd.op == OP_CHECK && enable) begin
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (idx_step && scan_end) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (space) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd_pop      = 1'b0;
    res_wr       = 1'b0;
    res_in.ev    = EV_ACK;
    res_in.slot  = '0;
    res_in.total = restart_counter;
    res_in.last  = 1'b1;
    hb_wr        = 1'b0;
    hb_idx       = cmd_idx;
    use_set      = 1'b0;
    use_clr      = 1'b0;
    cnt_inc      = 1'b0;
    idx_step     = 1'b0;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_REG: begin
              res_wr  = space;
              cmd_pop = space;
              if (free_any) begin
                res_in.ev   = EV_REGISTERED;
                res_in.slot = SLOT_FIELD_W'(free_idx);
                hb_idx      = free_idx;
                hb_wr       = space;
                use_set     = space;
              end else begin
                res_in.ev = EV_FULL;
              end
            end
            OP_KICK: begin
              res_wr      = space;
              cmd_pop     = space;
              res_in.slot = cmd.slot;
              hb_wr       = space && cmd.slot_ok;
            end
            OP_UNREG: begin
              res_wr      = space;
              cmd_pop     = space;
              res_in.slot = cmd.slot;
              use_clr     = space && cmd.slot_ok;
            end
            OP_CHECK: begin
              if (!enable) begin
                res_wr    = space;
                cmd_pop   = space;
                res_in.ev = EV_DONE;
              end
            end
            default: begin
              cmd_pop = 1'b0;
            end
          endcase
        end
      end
      B_SCAN: begin
        hb_idx = idx;
        if (hit) begin
          res_wr       = space;
          res_in.ev    = EV_RESTART;
          res_in.slot  = SLOT_FIELD_W'(idx);
          res_in.total = restart_counter + 32'd1;
          res_in.last  = 1'b0;
          hb_wr        = space;
          cnt_inc      = space;
          idx_step     = space;
        end else begin
          idx_step = 1'b1;
        end
      end
      B_DONE: begin
        res_wr    = space;
        cmd_pop   = space;
        res_in.ev = EV_DONE;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ENABLE:  enable        <= cfg_data[0];
        CFG_TIMEOUT: timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        default:     enable        <= enable;
      endcase
    end
  end

  // Advance sequencer, slot flags and restart counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= B_IDLE;
      idx             <= '0;
      slot_in_use     <= '0;
      restart_counter <= '0;
    end else begin
      state <= state_next;
      if (state == B_IDLE) begin
        idx <= '0;
      end else if (idx_step && !scan_end) begin
        idx <= idx + SLOT_W'(1);
      end
      if (use_set) begin
        slot_in_use[hb_idx] <= 1'b1;
      end
      if (use_clr) begin
        slot_in_use[cmd_idx] <= 1'b0;
      end
      if (cnt_inc) begin
        restart_counter <= restart_counter + 32'd1;
      end
    end
  end

  // Stamp heartbeats
  always_ff @(posedge clk) begin
    if (hb_wr) begin
      last_heartbeat[hb_idx] <= cmd.now;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (res_wr) begin
      rq[rq_wr_ptr] <= res_in;
    end
  end

  // Advance result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr_ptr <= 1'b0;
      rq_rd_ptr <= 1'b0;
      rq_count  <= 2'd0;
    end else begin
      if (res_wr) begin
        rq_wr_ptr <= ~rq_wr_ptr;
      end
      if (res_rd) begin
        rq_rd_ptr <= ~rq_rd_ptr;
      end
      rq_count <= rq_count + {1'b0, res_wr} - {1'b0, res_rd};
    end
  end

`ifndef ASSERT_OFF
  a_rq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> rq_count != 2'd2)
    else $error("result queue written while full");

  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_restart_counts: assert property (@(posedge clk) disable iff (rst)
    (res_wr && res_in.ev == EV_RESTART) |=> restart_counter == $past(restart_counter) + 32'd1)
    else $error("restart not counted");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (res_wr && state == B_SCAN) |-> !res_in.last)
    else $error("restart marked as final result");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> state == B_IDLE && rq_count == 2'd0)
    else $error("engine not idle after reset");
`endif

endmodule

@@ rtl/multi_slot_heartbeat_watchdog.sv @@
// Top level of the multi-slot heartbeat watchdog.
// Register, kick and unregister are served directly in the engine idle state; an enabled check
// scans each slot in turn and then writes done; a disabled check writes done directly.
// Commands are queued in the front queue, results in the result queue before they show.
// The engine takes one transaction a cycle except checks, while the result queue has space.
// Synchronous active-high reset clears queues, slot flags, counter; restores register defaults.
module multi_slot_heartbeat_watchdog import hbw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              kind,
  input  logic [SLOT_FIELD_W-1:0] slot,
  input  logic [TICK_W-1:0]       now_tick,
  output logic                    empty,
  input  logic                    pop,
  output logic [2:0]              event_res,
  output logic [SLOT_FIELD_W-1:0] slot_out,
  output logic [TICK_W-1:0]       restart_total,
  output logic                    last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t res;

  assign cfg_ready = 1'b1;

  hbw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .slot      (slot),
    .now_tick  (now_tick),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  hbw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  // Drive result ports from the head of the result queue
  assign event_res     = res.ev;
  assign slot_out      = res.slot;
  assign restart_total = res.total;
  assign last          = res.last;

endmodule
